FILE: sv/stt_pkg.sv
`timescale 1ns / 1ps
// shared types, token codes and keyword hash table for the source text tokenizer
package stt_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic        scan_error;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_WORD    = 4'd1,
      MODE_NUM     = 4'd2,
      MODE_STR     = 4'd3,
      MODE_CHOPEN  = 4'd4,
      MODE_CHBODY  = 4'd5,
      MODE_COMMENT = 4'd6,
      MODE_OPER    = 4'd7,
      MODE_ERROR   = 4'd8
   } mode_type;

   localparam logic [5:0] KIND_AND    = 6'd15;
   localparam logic [5:0] KIND_OR     = 6'd16;
   localparam logic [5:0] KIND_IDENT  = 6'd18;
   localparam logic [5:0] KIND_NUM    = 6'd19;
   localparam logic [5:0] KIND_STR    = 6'd20;
   localparam logic [5:0] KIND_CHAR   = 6'd21;
   localparam logic [5:0] KIND_PLUS   = 6'd22;
   localparam logic [5:0] KIND_MINUS  = 6'd23;
   localparam logic [5:0] KIND_STAR   = 6'd24;
   localparam logic [5:0] KIND_SLASH  = 6'd25;
   localparam logic [5:0] KIND_PCT    = 6'd26;
   localparam logic [5:0] KIND_CARET  = 6'd27;
   localparam logic [5:0] KIND_ASSIGN = 6'd28;
   localparam logic [5:0] KIND_EQ     = 6'd29;
   localparam logic [5:0] KIND_NOT    = 6'd30;
   localparam logic [5:0] KIND_NE     = 6'd31;
   localparam logic [5:0] KIND_GT     = 6'd32;
   localparam logic [5:0] KIND_GE     = 6'd33;
   localparam logic [5:0] KIND_LT     = 6'd34;
   localparam logic [5:0] KIND_LE     = 6'd35;
   localparam logic [5:0] KIND_LBRACE = 6'd36;
   localparam logic [5:0] KIND_RBRACE = 6'd37;
   localparam logic [5:0] KIND_LPAREN = 6'd38;
   localparam logic [5:0] KIND_RPAREN = 6'd39;
   localparam logic [5:0] KIND_LBRACK = 6'd40;
   localparam logic [5:0] KIND_RBRACK = 6'd41;
   localparam logic [5:0] KIND_COMMA  = 6'd42;
   localparam logic [5:0] KIND_END    = 6'd43;
   localparam logic [5:0] KIND_ERR    = 6'd44;

   localparam int          KEYWORD_COUNT = 18;
   localparam logic [63:0] HASH_SEED     = 64'd5381;
   localparam logic [63:0] HASH_REM      = 64'd193504585;

   localparam logic [63:0] KEYWORD_HASH [KEYWORD_COUNT] = '{
      64'd6385087377,   64'd6385115235,   64'd193495088,  64'd210712519067,
      64'd210706808356, 64'd6385593753,   64'd6385058142, 64'd6953552265174,
      64'd5863476,      64'd6385191717,   64'd6385192046, 64'd210732529790,
      64'd6953974653989, 64'd6385737701,  64'd210712121072, 64'd193486360,
      64'd5863686,      64'd193500239
   };

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || b == "_";
   endfunction

endpackage

FILE: sv/stt_scan_core.sv
`timescale 1ns / 1ps
// next-state and token logic for one source byte
module stt_scan_core #(
   parameter int POSITION_BITS = 16
) (
   input  stt_pkg::req_type          req_data,
   input  stt_pkg::mode_type         mode_cur,
   input  logic [63:0]               hash_cur,
   input  logic [POSITION_BITS-1:0]  begin_cur,
   input  logic [15:0]               count_cur,
   input  logic [POSITION_BITS-1:0]  pos_cur,
   input  logic [7:0]                pend_cur,
   input  logic                      err_cur,
   output stt_pkg::mode_type         mode_nxt,
   output logic [63:0]               hash_nxt,
   output logic [POSITION_BITS-1:0]  begin_nxt,
   output logic [15:0]               count_nxt,
   output logic [POSITION_BITS-1:0]  pos_nxt,
   output logic [7:0]                pend_nxt,
   output logic                      err_nxt,
   output stt_pkg::rsp_type          res0,
   output stt_pkg::rsp_type          res1,
   output logic [1:0]                res_cnt
);
   import stt_pkg::*;

   localparam int PW = POSITION_BITS;

   rsp_type     res [2];
   logic [1:0]  nres;
   logic        do_start;
   logic [5:0]  kw_kind;
   logic [5:0]  k;
   logic [7:0]  b;

   function automatic logic [15:0] to16(input logic [PW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   function automatic rsp_type mk(input logic [5:0] kind, input logic [15:0] st,
                                  input logic [15:0] len, input logic e);
      rsp_type r;
      r.token_kind   = kind;
      r.token_start  = st;
      r.token_length = len;
      r.scan_error   = e;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   // keyword match on the finished word hash, first entry wins
   always_comb begin
      kw_kind = KIND_IDENT;
      for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
         if (hash_cur == KEYWORD_HASH[i]) begin
            kw_kind = 6'(i);
         end
      end
   end

   always_comb begin
      b         = req_data.text_byte;
      mode_nxt  = mode_cur;
      hash_nxt  = hash_cur;
      begin_nxt = begin_cur;
      count_nxt = count_cur;
      pos_nxt   = pos_cur;
      pend_nxt  = pend_cur;
      err_nxt   = err_cur;
      res[0]    = '0;
      res[1]    = '0;
      nres      = 2'd0;
      do_start  = 1'b0;
      k         = '0;

      if (req_data.end_of_source || b == 8'd0) begin
         case (mode_cur)
            MODE_WORD: begin
               if (hash_cur != HASH_REM) begin
                  res[nres[0]] = mk(kw_kind, to16(begin_cur), count_cur, 1'b0);
                  nres = nres + 2'd1;
               end
            end
            MODE_NUM: begin
               res[nres[0]] = mk(KIND_NUM, to16(begin_cur), count_cur, 1'b0);
               nres = nres + 2'd1;
            end
            MODE_STR, MODE_CHOPEN, MODE_CHBODY: begin
               err_nxt = 1'b1;
               res[nres[0]] = mk(KIND_ERR, to16(begin_cur), count_cur, 1'b1);
               nres = nres + 2'd1;
            end
            MODE_OPER: begin
               case (pend_cur)
                  "=": k = KIND_ASSIGN;
                  "!": k = KIND_NOT;
                  ">": k = KIND_GT;
                  "<": k = KIND_LT;
                  default: k = KIND_ERR;
               endcase
               if (k == KIND_ERR) begin
                  err_nxt = 1'b1;
                  res[nres[0]] = mk(KIND_ERR, to16(begin_cur), count_cur, 1'b1);
               end else begin
                  res[nres[0]] = mk(k, to16(begin_cur), 16'd1, 1'b0);
               end
               nres = nres + 2'd1;
            end
            default: ;
         endcase
         res[nres[0]] = mk(KIND_END, to16(pos_cur), 16'd0, err_nxt);
         nres = nres + 2'd1;
         // back to reset state for the next source
         mode_nxt  = MODE_IDLE;
         hash_nxt  = HASH_SEED;
         begin_nxt = '0;
         count_nxt = '0;
         pos_nxt   = '0;
         pend_nxt  = '0;
         err_nxt   = 1'b0;
      end else begin
         case (mode_cur)
            MODE_WORD: begin
               if (is_word(b)) begin
                  hash_nxt = (hash_cur << 5) + hash_cur + {56'd0, b};
                  if (count_cur != 16'hFFFF) count_nxt = count_cur + 16'd1;
               end else if (hash_cur == HASH_REM) begin
                  mode_nxt = (b == CH_LF) ? MODE_IDLE : MODE_COMMENT;
               end else begin
                  res[nres[0]] = mk(kw_kind, to16(begin_cur), count_cur, 1'b0);
                  nres = nres + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_NUM: begin
               if (is_alpha(b) || is_digit(b) || b == ".") begin
                  if (count_cur != 16'hFFFF) count_nxt = count_cur + 16'd1;
               end else begin
                  res[nres[0]] = mk(KIND_NUM, to16(begin_cur), count_cur, 1'b0);
                  nres = nres + 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_STR: begin
               if (b == CH_DQUOTE) begin
                  res[nres[0]] = mk(KIND_STR, to16(begin_cur), count_cur, 1'b0);
                  nres = nres + 2'd1;
                  mode_nxt = MODE_IDLE;
               end else if (count_cur != 16'hFFFF) begin
                  count_nxt = count_cur + 16'd1;
               end
            end
            MODE_CHOPEN: mode_nxt = MODE_CHBODY;
            MODE_CHBODY: begin
               if (b == CH_SQUOTE) begin
                  res[nres[0]] = mk(KIND_CHAR, to16(begin_cur), 16'd1, 1'b0);
                  mode_nxt = MODE_IDLE;
               end else begin
                  err_nxt  = 1'b1;
                  res[nres[0]] = mk(KIND_ERR, to16(begin_cur), count_cur, 1'b1);
                  mode_nxt = MODE_ERROR;
               end
               nres = nres + 2'd1;
            end
            MODE_COMMENT: begin
               if (b == CH_LF) mode_nxt = MODE_IDLE;
            end
            MODE_OPER: begin
               if      (b == "=" && pend_cur == "=") k = KIND_EQ;
               else if (b == "=" && pend_cur == "!") k = KIND_NE;
               else if (b == "=" && pend_cur == ">") k = KIND_GE;
               else if (b == "=" && pend_cur == "<") k = KIND_LE;
               else if (b == "&" && pend_cur == "&") k = KIND_AND;
               else if (b == "|" && pend_cur == "|") k = KIND_OR;
               pend_nxt = '0;
               if (k != '0) begin
                  res[nres[0]] = mk(k, to16(begin_cur), 16'd2, 1'b0);
                  mode_nxt = MODE_IDLE;
               end else begin
                  case (pend_cur)
                     "=": k = KIND_ASSIGN;
                     "!": k = KIND_NOT;
                     ">": k = KIND_GT;
                     "<": k = KIND_LT;
                     default: k = KIND_ERR;
                  endcase
                  if (k == KIND_ERR) begin
                     // lone & or |
                     err_nxt  = 1'b1;
                     res[nres[0]] = mk(KIND_ERR, to16(begin_cur), count_cur, 1'b1);
                     mode_nxt = MODE_ERROR;
                  end else begin
                     res[nres[0]] = mk(k, to16(begin_cur), 16'd1, 1'b0);
                     do_start = 1'b1;
                  end
               end
               nres = nres + 2'd1;
            end
            MODE_ERROR: ;
            default: do_start = 1'b1;
         endcase

         if (do_start) begin
            begin_nxt = pos_cur;
            count_nxt = 16'd1;
            mode_nxt  = MODE_IDLE;
            k         = '0;
            if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
               mode_nxt = MODE_IDLE;
            end else if (is_alpha(b) || b == "_") begin
               hash_nxt = HASH_SEED * 64'd33 + {56'd0, b};
               mode_nxt = MODE_WORD;
            end else if (is_digit(b)) begin
               mode_nxt = MODE_NUM;
            end else if (b == CH_DQUOTE) begin
               begin_nxt = pos_cur + 1'b1;
               count_nxt = 16'd0;
               mode_nxt  = MODE_STR;
            end else if (b == CH_SQUOTE) begin
               begin_nxt = pos_cur + 1'b1;
               mode_nxt  = MODE_CHOPEN;
            end else if (b == "=" || b == "!" || b == ">" || b == "<" ||
                         b == "&" || b == "|") begin
               pend_nxt = b;
               mode_nxt = MODE_OPER;
            end else begin
               case (b)
                  "+": k = KIND_PLUS;
                  "-": k = KIND_MINUS;
                  "*": k = KIND_STAR;
                  "/": k = KIND_SLASH;
                  "%": k = KIND_PCT;
                  "^": k = KIND_CARET;
                  "{": k = KIND_LBRACE;
                  "}": k = KIND_RBRACE;
                  "(": k = KIND_LPAREN;
                  ")": k = KIND_RPAREN;
                  "[": k = KIND_LBRACK;
                  "]": k = KIND_RBRACK;
                  ",": k = KIND_COMMA;
                  default: k = KIND_ERR;
               endcase
               if (k == KIND_ERR) begin
                  err_nxt  = 1'b1;
                  res[nres[0]] = mk(KIND_ERR, to16(pos_cur), 16'd1, 1'b1);
                  mode_nxt = MODE_ERROR;
               end else begin
                  res[nres[0]] = mk(k, to16(pos_cur), 16'd1, 1'b0);
               end
               nres = nres + 2'd1;
            end
         end
         pos_nxt = pos_cur + 1'b1;
      end

      if (nres == 2'd1) res[0].last_of_run = 1'b1;
      if (nres == 2'd2) res[1].last_of_run = 1'b1;
   end

   assign res0    = res[0];
   assign res1    = res[1];
   assign res_cnt = nres;

endmodule

FILE: sv/source_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// top level of the source text tokenizer: scan state registers and result queue
//
// source bytes come in on the req_ channel, one byte per beat; a beat with
// end_of_source set (or a zero byte) closes the source, flushes any open token
// and produces the end token. tokens leave on the rsp_ channel one per beat,
// last_of_run marking the final token caused by a given input byte.
// each accepted byte is scanned in the cycle it is taken; its tokens (zero,
// one or two) are registered into a four-entry result queue whose head drives
// rsp_. a byte is taken every cycle while the queue has room for two tokens,
// so the input runs at one byte per cycle as long as the receiver takes
// tokens as fast as they are made; the two tokens of one byte leave on
// separate output beats.
// reset clears the scan state to idle at offset zero and empties the queue.
// when the receiver stalls, the queue fills and req_ready drops once fewer
// than two entries are free; nothing is dropped.
module source_text_tokenizer_unit #(
   parameter int POSITION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stt_pkg::rsp_type rsp_data
);
   import stt_pkg::*;

   localparam int PW = POSITION_BITS;

   mode_type        mode_ff, mode_in;
   logic [63:0]     hash_ff, hash_in;
   logic [PW-1:0]   begin_ff, begin_in;
   logic [15:0]     count_ff, count_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [7:0]      pend_ff, pend_in;
   logic            err_ff, err_in;

   rsp_type         res0, res1;
   logic [1:0]      res_cnt;

   rsp_type         q_ff [4];
   logic [1:0]      wr_ff, rd_ff;
   logic [2:0]      q_count_ff;
   logic            push_beat, pop_beat;
   logic [1:0]      push_n;

   stt_scan_core #(.POSITION_BITS(PW)) u_core (
      .req_data  (req_data),
      .mode_cur  (mode_ff),
      .hash_cur  (hash_ff),
      .begin_cur (begin_ff),
      .count_cur (count_ff),
      .pos_cur   (pos_ff),
      .pend_cur  (pend_ff),
      .err_cur   (err_ff),
      .mode_nxt  (mode_in),
      .hash_nxt  (hash_in),
      .begin_nxt (begin_in),
      .count_nxt (count_in),
      .pos_nxt   (pos_in),
      .pend_nxt  (pend_in),
      .err_nxt   (err_in),
      .res0      (res0),
      .res1      (res1),
      .res_cnt   (res_cnt)
   );

   assign req_ready = q_count_ff <= 3'd2;
   assign push_beat = req_valid && req_ready;
   assign push_n    = push_beat ? res_cnt : 2'd0;
   assign rsp_valid = q_count_ff != 3'd0;
   assign pop_beat  = rsp_valid && rsp_ready;
   assign rsp_data  = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         hash_ff  <= HASH_SEED;
         begin_ff <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         pend_ff  <= '0;
         err_ff   <= 1'b0;
      end else if (push_beat) begin
         mode_ff  <= mode_in;
         hash_ff  <= hash_in;
         begin_ff <= begin_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         pend_ff  <= pend_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) q_ff[wr_ff] <= res0;
      if (push_n == 2'd2) q_ff[wr_ff + 2'd1] <= res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff      <= '0;
         rd_ff      <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ff      <= wr_ff + push_n;
         rd_ff      <= rd_ff + {1'b0, pop_beat};
         q_count_ff <= q_count_ff + {1'b0, push_n} - {2'b0, pop_beat};
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= 3'd4) else $error("result queue overflow");

   a_eos_resets: assert property (@(posedge clock) disable iff (reset)
      push_beat && req_data.end_of_source |=> pos_ff == '0 && mode_ff == MODE_IDLE && !err_ff)
      else $error("end of source did not restore scan state");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff && !push_beat |=> err_ff) else $error("error flag dropped while idle");

   a_error_mode_flag: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ERROR |-> err_ff) else $error("error mode without error flag");

endmodule
